[rtl/ipv6_source_address_select_unit_defines.svh]
// Assertion macros used by the source address select RTL.
`ifndef IPV6_SOURCE_ADDRESS_SELECT_UNIT_DEFINES_SVH
`define IPV6_SOURCE_ADDRESS_SELECT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/ipv6sas_pkg.sv]
// Types, codes and helper functions for the source address select unit.
package ipv6sas_pkg;

   localparam logic [1:0] STATE_PREFERRED  = 2'd1;
   localparam logic [1:0] STATE_DEPRECATED = 2'd2;

   localparam logic STATUS_CHOSEN = 1'b0;
   localparam logic STATUS_NONE   = 1'b1;

   localparam logic [9:0] LINK_LOCAL_PREFIX = 10'h3FA;

   typedef struct packed {
      logic [63:0] dest_high;
      logic [63:0] dest_low;
      logic [63:0] cand_high;
      logic [63:0] cand_low;
      logic [1:0]  cand_state;
      logic        cand_present;
      logic [63:0] req_high;
      logic [63:0] req_low;
      logic        last_item;
   } req_payload_type;

   typedef struct packed {
      logic        status;
      logic [63:0] src_high;
      logic [63:0] src_low;
      logic [7:0]  match_bits;
   } rsp_payload_type;

   typedef struct packed {
      logic       usable;
      logic       dep;
      logic [7:0] match;
   } score_type;

   // leading zeros of one byte, 0..8
   function automatic logic [3:0] lzc8(input logic [7:0] v);
      logic [3:0] n;
      logic       done;
      n    = '0;
      done = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         if (!done) begin
            if (v[i]) begin
               done = 1'b1;
            end else begin
               n = n + 4'd1;
            end
         end
      end
      return n;
   endfunction

   // leading zeros of a 32-bit word, 0..32
   function automatic logic [5:0] lzc32(input logic [31:0] v);
      logic [5:0] n;
      logic       done;
      n    = '0;
      done = 1'b0;
      for (int j = 3; j >= 0; j--) begin
         if (!done) begin
            if (v[8*j +: 8] != 8'd0) begin
               n    = n + {2'b00, lzc8(v[8*j +: 8])};
               done = 1'b1;
            end else begin
               n = n + 6'd8;
            end
         end
      end
      return n;
   endfunction

   function automatic logic is_loop_addr(input logic [63:0] hi, input logic [63:0] lo);
      return (hi == 64'd0) && (lo == 64'd1);
   endfunction

   function automatic logic is_link_addr(input logic [63:0] hi);
      return hi[63:54] == LINK_LOCAL_PREFIX;
   endfunction

endpackage

[rtl/ipv6sas_score.sv]
// Candidate qualification and common prefix length against the destination.
module ipv6sas_score
   import ipv6sas_pkg::*;
(
   input  req_payload_type item,
   output score_type       score
);

   logic [127:0] diff;
   logic [7:0]   lead_match;
   logic         state_ok;
   logic         req_ok;
   logic         scope_ok;
   logic         done;

   assign diff = {item.cand_high ^ item.dest_high, item.cand_low ^ item.dest_low};

   // count leading zeros word by word, 128 when the addresses are equal
   always_comb begin
      lead_match = '0;
      done       = 1'b0;
      for (int k = 3; k >= 0; k--) begin
         if (!done) begin
            if (diff[32*k +: 32] != 32'd0) begin
               lead_match = lead_match + {2'b00, lzc32(diff[32*k +: 32])};
               done       = 1'b1;
            end else begin
               lead_match = lead_match + 8'd32;
            end
         end
      end
   end

   assign state_ok = (item.cand_state == STATE_PREFERRED) ||
                     (item.cand_state == STATE_DEPRECATED);

   assign req_ok = ((item.req_high == 64'd0) && (item.req_low == 64'd0)) ||
                   ((item.req_high == item.cand_high) && (item.req_low == item.cand_low));

   always_comb begin
      priority if (is_loop_addr(item.dest_high, item.dest_low)) begin
         scope_ok = is_loop_addr(item.cand_high, item.cand_low);
      end else if (is_link_addr(item.dest_high)) begin
         scope_ok = is_link_addr(item.cand_high);
      end else begin
         scope_ok = !is_link_addr(item.cand_high) &&
                    !is_loop_addr(item.cand_high, item.cand_low);
      end
   end

   assign score.usable = item.cand_present && state_ok && req_ok && scope_ok;
   assign score.dep    = (item.cand_state == STATE_DEPRECATED);
   assign score.match  = lead_match;

endmodule

[rtl/ipv6sas_best.sv]
// Running best candidate of one selection and the result it yields.
module ipv6sas_best
   import ipv6sas_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  req_payload_type item,
   input  score_type       score,
   output rsp_payload_type result
);

   logic        have_best_ff, have_best_in;
   logic        best_dep_ff, best_dep_in;
   logic [7:0]  best_match_ff, best_match_in;
   logic [63:0] best_high_ff, best_high_in;
   logic [63:0] best_low_ff, best_low_in;

   logic        take;
   logic        upd_have;
   logic        upd_dep;
   logic [7:0]  upd_match;
   logic [63:0] upd_high;
   logic [63:0] upd_low;

   // earlier candidate keeps a tie
   assign take = score.usable &&
                 (!have_best_ff ||
                  (best_dep_ff && !score.dep) ||
                  ((best_dep_ff == score.dep) && (score.match > best_match_ff)));

   assign upd_have  = have_best_ff | take;
   assign upd_dep   = take ? score.dep      : best_dep_ff;
   assign upd_match = take ? score.match    : best_match_ff;
   assign upd_high  = take ? item.cand_high : best_high_ff;
   assign upd_low   = take ? item.cand_low  : best_low_ff;

   always_comb begin
      result.status     = upd_have ? STATUS_CHOSEN : STATUS_NONE;
      result.src_high   = upd_have ? upd_high  : 64'd0;
      result.src_low    = upd_have ? upd_low   : 64'd0;
      result.match_bits = upd_have ? upd_match : 8'd0;
   end

   always_comb begin
      have_best_in  = have_best_ff;
      best_dep_in   = best_dep_ff;
      best_match_in = best_match_ff;
      best_high_in  = best_high_ff;
      best_low_in   = best_low_ff;
      if (advance) begin
         if (item.last_item) begin
            have_best_in = 1'b0;
            best_dep_in  = 1'b1;
         end else begin
            have_best_in  = upd_have;
            best_dep_in   = upd_dep;
            best_match_in = upd_match;
            best_high_in  = upd_high;
            best_low_in   = upd_low;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_best_ff <= 1'b0;
         best_dep_ff  <= 1'b1;
      end else begin
         have_best_ff <= have_best_in;
         best_dep_ff  <= best_dep_in;
      end
   end

   always_ff @(posedge clock) begin
      best_match_ff <= best_match_in;
      best_high_ff  <= best_high_in;
      best_low_ff   <= best_low_in;
   end

endmodule

[rtl/ipv6_source_address_select_unit.sv]
// IPv6 source address select: one candidate item per cycle, result on the last item.
// An accepted item is scored in the next cycle; a last item's result goes through the input
// register and then the output register to rsp_valid. Throughput: one item per cycle.
// Stalls come only from an unread result holding the output register.
// Reset (synchronous, active high) empties both stages and clears the running best.
`include "ipv6_source_address_select_unit_defines.svh"
module ipv6_source_address_select_unit
   import ipv6sas_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   // input stage
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_ff, in_in;

   // output stage
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic            req_fire;
   logic            advance;
   logic            rsp_load;
   logic            rsp_none_clean;
   score_type       score;
   rsp_payload_type result;

   // Advance the held item unless it is a last item and the result slot is
   // still occupied by a result nobody has taken.
   assign advance   = in_valid_ff && (!in_ff.last_item || !rsp_valid_ff || rsp_ready);
   assign rsp_load  = advance && in_ff.last_item;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_in       = req_payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Score the held candidate against its own destination.
   ipv6sas_score u_score (
      .item  (in_ff),
      .score (score)
   );

   // Fold the score into the running best; drop the best after a last item.
   ipv6sas_best u_best (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_ff),
      .score   (score),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers hold without reset
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a not-available result carries an all-zero address and length
   assign rsp_none_clean = (rsp_ff.src_high == 64'd0) && (rsp_ff.src_low == 64'd0) &&
                           (rsp_ff.match_bits == 8'd0);

   `ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !in_valid_ff, req_ready)
   `ASSERT_NEXT(a_last_gives_result, clock, reset, rsp_load, rsp_valid_ff)
   `ASSERT_IMPLIES(a_no_result_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !rsp_load)
   `ASSERT_IMPLIES(a_none_is_zero, clock, reset, rsp_valid_ff && rsp_ff.status, rsp_none_clean)

endmodule

[bench/ipv6_source_address_select_unit_tb.sv]
// Self-checking bench for the IPv6 source address select unit.
module ipv6_source_address_select_unit_tb;
   import ipv6sas_pkg::*;

   // Candidate states that the package leaves unnamed.
   localparam logic [1:0] STATE_TENTATIVE  = 2'd0;
   localparam logic [1:0] STATE_DAD_FAILED = 2'd3;

   // The result follows the last item through the output register, so a short settle suffices.
   localparam int SETTLE_CYCLES = 8;
   // Length of the forced result hold-off that backs the block up.
   localparam int HOLD_CYCLES   = 200;
   // Cycles with no item moving on either side before the run is abandoned.
   localparam int QUIET_LIMIT   = 3000;

   localparam logic [127:0] LOOPBACK  = 128'd1;
   localparam logic [127:0] GLOBAL_DA = 128'h2001_0db8_0001_0002_0000_0000_0000_0010;
   localparam logic [127:0] LINK_DA   = 128'hfe80_0000_0000_0000_0211_22ff_fe33_4455;

   // Running best source per selection, and the picks still owed by the block.
   class address_pick_board;
      bit              have_best  = 1'b0;
      bit              best_dep   = 1'b1;
      logic [7:0]      best_match = 8'd0;
      logic [127:0]    best_addr  = '0;
      rsp_payload_type pending_picks[$];
      int              fault_count  = 0;
      int              chosen_count = 0;
      int              none_count   = 0;

      function void clear_best();
         have_best  = 1'b0;
         best_dep   = 1'b1;
         best_match = 8'd0;
         best_addr  = '0;
      endfunction

      function int unsigned prefix_match(input logic [127:0] a, input logic [127:0] b);
         logic [127:0] diff;
         int unsigned  n;
         diff = a ^ b;
         n    = 0;
         for (int i = 127; i >= 0 && !diff[i]; i--) n++;
         return n;
      endfunction

      function bit is_loop(input logic [127:0] a);
         return a == LOOPBACK;
      endfunction

      function bit is_link(input logic [127:0] a);
         return a[127:118] == LINK_LOCAL_PREFIX;
      endfunction

      function bit scope_ok(input logic [127:0] src, input logic [127:0] dst);
         if (is_loop(dst)) return is_loop(src);
         if (is_link(dst)) return is_link(src);
         return !is_link(src) && !is_loop(src);
      endfunction

      // Fold one accepted item into the running best; queue a pick on the last item.
      function void take_candidate(input req_payload_type p);
         logic [127:0]    cand;
         logic [127:0]    dst;
         logic [127:0]    want;
         bit              dep;
         logic [7:0]      m;
         rsp_payload_type e;
         cand = {p.cand_high, p.cand_low};
         dst  = {p.dest_high, p.dest_low};
         want = {p.req_high, p.req_low};
         if (p.cand_present &&
             (p.cand_state == STATE_PREFERRED || p.cand_state == STATE_DEPRECATED) &&
             (want == '0 || want == cand) && scope_ok(cand, dst)) begin
            dep = (p.cand_state == STATE_DEPRECATED);
            m   = 8'(prefix_match(cand, dst));
            if (!have_best || (best_dep && !dep) || (best_dep == dep && m > best_match)) begin
               have_best  = 1'b1;
               best_dep   = dep;
               best_match = m;
               best_addr  = cand;
            end
         end
         if (p.last_item) begin
            if (have_best) begin
               e.status     = STATUS_CHOSEN;
               e.src_high   = best_addr[127:64];
               e.src_low    = best_addr[63:0];
               e.match_bits = best_match;
            end else begin
               e.status     = STATUS_NONE;
               e.src_high   = '0;
               e.src_low    = '0;
               e.match_bits = '0;
            end
            pending_picks.push_back(e);
            clear_best();
         end
      endfunction

      function void check_pick(input rsp_payload_type r);
         rsp_payload_type e;
         if (pending_picks.size() == 0) begin
            $error("unexpected result: status %0d src %h_%h match %0d",
                   r.status, r.src_high, r.src_low, r.match_bits);
            fault_count++;
            return;
         end
         e = pending_picks.pop_front();
         if (e.status === STATUS_CHOSEN) chosen_count++;
         else none_count++;
         if (r.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, r.status);
            fault_count++;
         end
         if (r.src_high !== e.src_high) begin
            $error("src_high: expected %h, got %h", e.src_high, r.src_high);
            fault_count++;
         end
         if (r.src_low !== e.src_low) begin
            $error("src_low: expected %h, got %h", e.src_low, r.src_low);
            fault_count++;
         end
         if (r.match_bits !== e.match_bits) begin
            $error("match_bits: expected %0d, got %0d", e.match_bits, r.match_bits);
            fault_count++;
         end
      endfunction
   endclass

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;

   address_pick_board board;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_token     = 0;
   int hold_seen      = 0;
   int stall_left     = 0;
   int quiet_cycles   = 0;
   int items_sent     = 0;
   int selections     = 0;

   ipv6_source_address_select_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: check every accepted result, then pick the next ready level.
   // A new hold token starts a long hold-off that this process counts down itself.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) board.check_pick(rsp_payload);
         if (hold_token != hold_seen) begin
            hold_seen  = hold_token;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: give up when nothing moves on either side for too long.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [127:0] rand_addr();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [127:0] link_addr();
      logic [127:0] a;
      a = rand_addr();
      a[127:118] = LINK_LOCAL_PREFIX;
      return a;
   endfunction

   // Copy the destination down to a random prefix length, then scramble the rest.
   function automatic logic [127:0] near_addr(input logic [127:0] d);
      int unsigned  k;
      logic [127:0] a;
      logic [127:0] below;
      k = $urandom_range(0, 128);
      if (k == 128) return d;
      a = d;
      a[127 - k] = ~d[127 - k];
      below = {128{1'b1}} >> (k + 1);
      return a ^ (rand_addr() & below);
   endfunction

   function automatic logic [127:0] pick_dest();
      logic [127:0] a;
      case ($urandom_range(0, 9))
         0: a = LOOPBACK;
         1, 2, 3: a = link_addr();
         4: begin
            // just outside fe80::/10 on either side
            a = rand_addr();
            a[127:118] = $urandom_range(0, 1) ? 10'h3F9 : 10'h3FB;
         end
         5: a = $urandom_range(0, 1) ? {128{1'b0}} : {128{1'b1}};
         default: a = rand_addr();
      endcase
      return a;
   endfunction

   function automatic logic [127:0] pick_cand(input logic [127:0] d);
      logic [127:0] a;
      case ($urandom_range(0, 11))
         0: a = LOOPBACK;
         1: a = link_addr();
         2: a = rand_addr();
         3: a = $urandom_range(0, 1) ? {128{1'b0}} : {128{1'b1}};
         default: a = near_addr(d);
      endcase
      return a;
   endfunction

   function automatic logic [1:0] pick_state();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return STATE_PREFERRED;
      if (r < 75) return STATE_DEPRECATED;
      if (r < 87) return STATE_TENTATIVE;
      return STATE_DAD_FAILED;
   endfunction

   function automatic req_payload_type item_of(input logic [127:0] dst,
                                               input logic [127:0] cand,
                                               input logic [1:0]   st,
                                               input logic         pres,
                                               input logic [127:0] want,
                                               input logic         closes);
      req_payload_type p;
      p.dest_high    = dst[127:64];
      p.dest_low     = dst[63:0];
      p.cand_high    = cand[127:64];
      p.cand_low     = cand[63:0];
      p.cand_state   = st;
      p.cand_present = pres;
      p.req_high     = want[127:64];
      p.req_low      = want[63:0];
      p.last_item    = closes;
      return p;
   endfunction

   // Offer one item, idling first at the current rate; hold it until accepted.
   task automatic send_item(input req_payload_type p);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      board.take_candidate(p);
      items_sent++;
   endtask

   // One selection: mostly a tidy run against one destination, sometimes noise.
   task automatic send_selection();
      logic [127:0] dst;
      logic [127:0] want;
      logic [127:0] cands [0:11];
      int           len;
      bit           tidy;
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
      tidy = ($urandom_range(0, 99) < 85);
      dst  = pick_dest();
      for (int i = 0; i < len; i++) cands[i] = pick_cand(dst);
      case ($urandom_range(0, 9))
         0, 1: want = cands[$urandom_range(0, len - 1)];
         2: want = rand_addr();
         default: want = '0;
      endcase
      for (int i = 0; i < len; i++) begin
         if (tidy) begin
            send_item(item_of(dst, cands[i], pick_state(), ($urandom_range(0, 19) != 0),
                              want, i == len - 1));
         end else begin
            // noise: destination moves per item, any state, presence at random
            dst = pick_dest();
            send_item(item_of(dst, $urandom_range(0, 1) ? pick_cand(dst) : rand_addr(),
                              2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              want, i == len - 1));
         end
      end
      selections++;
   endtask

   // Drop valid and hold off until every owed pick has arrived, then settle.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (board.pending_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int s_pct, input int r_pct, input int upto);
      send_idle_pct  = s_pct;
      recv_stall_pct = r_pct;
      while (items_sent < upto) send_selection();
      wait_drain();
   endtask

   initial begin
      board = new;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, scope rules, states and the selection rules.
      // empty item with junk in the candidate fields: nothing chosen
      send_item(item_of(GLOBAL_DA, {128{1'b1}}, STATE_PREFERRED, 1'b0, '0, 1'b1));
      // all ones everywhere, requested source equal to the candidate
      send_item(item_of({128{1'b1}}, {128{1'b1}}, STATE_PREFERRED, 1'b1, {128{1'b1}}, 1'b1));
      // all zero destination and candidate count as global
      send_item(item_of('0, '0, STATE_PREFERRED, 1'b1, '0, 1'b1));
      // loopback to loopback, then loopback destination refusing a global source
      send_item(item_of(LOOPBACK, LOOPBACK, STATE_PREFERRED, 1'b1, '0, 1'b1));
      send_item(item_of(LOOPBACK, GLOBAL_DA, STATE_PREFERRED, 1'b1, '0, 1'b1));
      // link-local destination takes only the link-local candidate
      send_item(item_of(LINK_DA, GLOBAL_DA, STATE_PREFERRED, 1'b1, '0, 1'b0));
      send_item(item_of(LINK_DA, LOOPBACK, STATE_PREFERRED, 1'b1, '0, 1'b0));
      send_item(item_of(LINK_DA, LINK_DA ^ 128'h1, STATE_DEPRECATED, 1'b1, '0, 1'b1));
      // global destination refuses link-local and loopback sources
      send_item(item_of(GLOBAL_DA, LINK_DA, STATE_PREFERRED, 1'b1, '0, 1'b0));
      send_item(item_of(GLOBAL_DA, LOOPBACK, STATE_PREFERRED, 1'b1, '0, 1'b1));
      // tentative, duplicate-detection failure and an empty last item: nothing chosen
      send_item(item_of(GLOBAL_DA, GLOBAL_DA, STATE_TENTATIVE, 1'b1, '0, 1'b0));
      send_item(item_of(GLOBAL_DA, GLOBAL_DA, STATE_DAD_FAILED, 1'b1, '0, 1'b0));
      send_item(item_of(GLOBAL_DA, GLOBAL_DA, STATE_PREFERRED, 1'b0, '0, 1'b1));
      // preferred with no common prefix beats a deprecated near match
      send_item(item_of(GLOBAL_DA, GLOBAL_DA ^ 128'h1, STATE_DEPRECATED, 1'b1, '0, 1'b0));
      send_item(item_of(GLOBAL_DA, GLOBAL_DA ^ {1'b1, 127'd0}, STATE_PREFERRED, 1'b1, '0,
                        1'b1));
      // preferred kept over an exact deprecated match, first kept on a tie
      send_item(item_of(GLOBAL_DA, GLOBAL_DA ^ (128'd1 << 100), STATE_PREFERRED, 1'b1, '0,
                        1'b0));
      send_item(item_of(GLOBAL_DA, GLOBAL_DA, STATE_DEPRECATED, 1'b1, '0, 1'b0));
      send_item(item_of(GLOBAL_DA, GLOBAL_DA ^ (128'd1 << 100) ^ 128'h5, STATE_PREFERRED,
                        1'b1, '0, 1'b1));
      // requested source filters out a better candidate
      send_item(item_of(GLOBAL_DA, GLOBAL_DA, STATE_PREFERRED, 1'b1, GLOBAL_DA ^ 128'h3,
                        1'b0));
      send_item(item_of(GLOBAL_DA, GLOBAL_DA ^ 128'h3, STATE_DEPRECATED, 1'b1,
                        GLOBAL_DA ^ 128'h3, 1'b1));
      // requested source that matches nobody
      send_item(item_of(GLOBAL_DA, GLOBAL_DA, STATE_PREFERRED, 1'b1, 128'h1234, 1'b1));
      // destination changes mid-selection; each candidate scored on its own item
      send_item(item_of(GLOBAL_DA, GLOBAL_DA ^ 128'hff, STATE_PREFERRED, 1'b1, '0, 1'b0));
      send_item(item_of(LINK_DA, LINK_DA ^ 128'h7f, STATE_PREFERRED, 1'b1, '0, 1'b1));
      selections += 13;
      wait_drain();

      // Random phases, each with its own idle mix.
      run_phase(0, 0, 120);
      run_phase(66, 0, 210);
      run_phase(0, 66, 300);
      run_phase(34, 34, 390);

      // Pressure: stall the result side for a long stretch while items keep coming.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_token    <= hold_token + 1;
      while (items_sent < 450) send_selection();
      wait_drain();

      $display("Covered %0d items in %0d selections: %0d picks chosen, %0d with none.",
               items_sent, selections, board.chosen_count, board.none_count);
      $display("Idle mixes on both sides plus a %0d-cycle result hold-off were exercised.",
               HOLD_CYCLES);
      if (board.fault_count == 0 && board.pending_picks.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
